### rtl/core/priority_round_robin_thread_scheduler_top_macros.svh
// assertion macros used by the scheduler top level
`ifndef PRIORITY_ROUND_ROBIN_THREAD_SCHEDULER_TOP_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_THREAD_SCHEDULER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, off while reset is high
`define PRRTS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check, also during reset
`define PRRTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRRTS_ASSERT(lbl, clk, rst, prop, msg)
`define PRRTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/prrts_pkg.sv
// types and constants of the thread scheduler
package prrts_pkg;
  localparam int THREAD_SLOTS_DEF = 8;
  localparam int SEL_W   = 6;
  localparam int MODE_W  = 3;
  localparam int PRIO_W  = 8;
  localparam int TICK_W  = 32;
  localparam int SLICE_W = 16;
  localparam int OIDX_W  = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SWITCH = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CREATE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SLEEP  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EXIT   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BLOCK  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 1'b1;
  localparam logic [SLICE_W-1:0] QUANTUM_RST = 16'd10;
  localparam logic [TICK_W-1:0]  PERIOD_RST  = 32'd10;

  typedef enum logic [2:0] {
    ST_READY, ST_RUNNING, ST_BLOCKED, ST_SLEEPING, ST_TERMINATED
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_TICK, OP_CREATE, OP_SLEEP, OP_EXIT, OP_BLOCK, OP_DEMOTE, OP_RUN
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SEL_W-1:0]  sel;
    logic [PRIO_W-1:0] prio;
    logic [TICK_W-1:0] data;
    logic [TICK_W-1:0] ticks;
    logic [SEL_W-1:0]  start;
    logic [SEL_W:0]    total;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [SEL_W-1:0]  rot;
    logic [SEL_W-1:0]  idx;
  } cand_t;
endpackage

### rtl/core/prrts_intf.sv
// handshake channels of the thread scheduler
interface prrts_in_if;
  logic                          valid;
  logic                          ready;
  logic [prrts_pkg::MODE_W-1:0]  mode;
  logic [prrts_pkg::PRIO_W-1:0]  new_priority;
  logic [prrts_pkg::TICK_W-1:0]  sleep_ticks;
  modport source (output valid, mode, new_priority, sleep_ticks, input ready);
  modport sink (input valid, mode, new_priority, sleep_ticks, output ready);
endinterface

interface prrts_out_if;
  logic                          valid;
  logic                          ready;
  logic                          switch_request;
  logic                          next_valid;
  logic [prrts_pkg::OIDX_W-1:0]  next_index;
  logic                          created_ok;
  logic [prrts_pkg::OIDX_W-1:0]  created_index;
  logic [prrts_pkg::TICK_W-1:0]  tick_now;
  modport source (output valid, switch_request, next_valid, next_index, created_ok,
                  created_index, tick_now, input ready);
  modport sink (input valid, switch_request, next_valid, next_index, created_ok,
                created_index, tick_now, output ready);
endinterface

interface prrts_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [prrts_pkg::CFG_IDX_W-1:0] index;
  logic [prrts_pkg::TICK_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/priority_round_robin_thread_scheduler_top.sv
// top level of the priority round robin thread scheduler
//
// Thread scheduler with a table of THREAD_SLOTS threads held in a row of slot
// cells. Each input transaction is one event (tick, switch, create, sleep,
// exit, block) and yields exactly one result transaction. Events are handled
// one at a time. Tick, create, sleep, exit and block pass from S_EXEC to S_DONE
// and the output register; a switch that dispatches a thread passes S_EXEC,
// S_SCAN, S_DEMOTE and S_RUN, skips S_RUN when nothing is runnable and
// goes straight to S_DONE on an empty table. In S_SCAN the best
// candidate (highest priority, then nearest slot after the current one) moves
// one cell per cycle down the row. A new event is accepted as soon as the
// previous one has left the control path, even while its result still waits
// in the output register.
// Configuration writes are always ready; write them only while idle.
`include "priority_round_robin_thread_scheduler_top_macros.svh"

module priority_round_robin_thread_scheduler_top #(
  parameter int THREAD_SLOTS = prrts_pkg::THREAD_SLOTS_DEF
) (
  input logic        clk,
  input logic        rst,
  prrts_in_if.sink   sched_in,
  prrts_out_if.source sched_out,
  prrts_cfg_if.sink  cfg
);
  localparam int IW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int TW = $clog2(THREAD_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_DEMOTE, S_RUN, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [prrts_pkg::SLICE_W-1:0] quantum;
  logic [prrts_pkg::TICK_W-1:0]  dflt_period;

  // latched event
  logic [prrts_pkg::MODE_W-1:0]  mode;
  logic [prrts_pkg::PRIO_W-1:0]  new_prio;
  logic [prrts_pkg::TICK_W-1:0]  delay;

  // scheduler state
  logic [TW-1:0]                 total;
  logic [IW-1:0]                 rs;
  logic                          rv;
  logic [prrts_pkg::TICK_W-1:0]  ticks;
  logic [prrts_pkg::SLICE_W-1:0] slice;
  logic [IW-1:0]                 scan_cnt;
  logic [IW-1:0]                 win;

  // result being built
  logic                          req;
  logic                          nvalid;
  logic                          cok;
  logic [IW-1:0]                 cidx;

  prrts_pkg::cmd_t               cmd;
  prrts_pkg::cand_t              cand_w [THREAD_SLOTS+1];
  prrts_pkg::status_t            status_w [THREAD_SLOTS];
  logic                          cur_run;
  logic [TW-1:0]                 rs_p1;
  logic [TW-1:0]                 start;
  logic [prrts_pkg::SLICE_W-1:0] slice_dec;

  assign cfg.ready      = 1'b1;
  assign sched_in.ready = (state == S_IDLE);

  assign cur_run = rv && (TW'(rs) < total) && (status_w[rs] == prrts_pkg::ST_RUNNING);
  assign rs_p1   = TW'(rs) + TW'(1);
  // round robin starts after the current slot, wrapping at the table end
  assign start   = (rs_p1 >= total) ? '0 : rs_p1;
  assign slice_dec = (slice != '0) ? slice - 16'd1 : slice;

  // command broadcast to the slot cells
  always_comb begin
    cmd       = '0;
    cmd.op    = prrts_pkg::OP_NONE;
    cmd.prio  = new_prio;
    cmd.ticks = ticks;
    cmd.start = prrts_pkg::SEL_W'(start);
    cmd.total = (prrts_pkg::SEL_W+1)'(total);
    cmd.sel   = prrts_pkg::SEL_W'(rs);
    cmd.data  = delay;
    unique case (state)
      S_EXEC: begin
        unique case (mode)
          prrts_pkg::MODE_TICK: cmd.op = prrts_pkg::OP_TICK;
          prrts_pkg::MODE_CREATE: begin
            if (total < TW'(THREAD_SLOTS)) cmd.op = prrts_pkg::OP_CREATE;
            cmd.sel  = prrts_pkg::SEL_W'(total);
            cmd.data = dflt_period;
          end
          prrts_pkg::MODE_SLEEP: if (cur_run) cmd.op = prrts_pkg::OP_SLEEP;
          prrts_pkg::MODE_EXIT:  if (cur_run) cmd.op = prrts_pkg::OP_EXIT;
          prrts_pkg::MODE_BLOCK: if (cur_run) cmd.op = prrts_pkg::OP_BLOCK;
          default: ;
        endcase
      end
      S_DEMOTE: if (cur_run && cand_w[THREAD_SLOTS].valid) cmd.op = prrts_pkg::OP_DEMOTE;
      S_RUN: begin
        cmd.op  = prrts_pkg::OP_RUN;
        cmd.sel = prrts_pkg::SEL_W'(win);
      end
      default: ;
    endcase
  end

  // row of slot cells; the candidate chain starts empty
  assign cand_w[0] = '0;
  for (genvar g = 0; g < THREAD_SLOTS; g++) begin : g_cell
    prrts_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .my_id    (prrts_pkg::SEL_W'(g)),
      .cand_in  (cand_w[g]),
      .cand_out (cand_w[g+1]),
      .status_o (status_w[g])
    );
  end

  // control and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      quantum         <= prrts_pkg::QUANTUM_RST;
      dflt_period     <= prrts_pkg::PERIOD_RST;
      total           <= '0;
      rs              <= '0;
      rv              <= 1'b0;
      ticks           <= '0;
      slice           <= '0;
      scan_cnt        <= '0;
      sched_out.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          prrts_pkg::CFG_QUANTUM: quantum     <= cfg.data[prrts_pkg::SLICE_W-1:0];
          prrts_pkg::CFG_PERIOD:  dflt_period <= cfg.data;
          default: ;
        endcase
      end
      // in S_DONE the output register is loaded below instead
      if (sched_out.valid && sched_out.ready && state != S_DONE) sched_out.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (sched_in.valid) begin
            mode     <= sched_in.mode;
            new_prio <= sched_in.new_priority;
            delay    <= sched_in.sleep_ticks;
            req      <= 1'b0;
            nvalid   <= 1'b0;
            cok      <= 1'b0;
            cidx     <= '0;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          unique case (mode)
            prrts_pkg::MODE_TICK: begin
              ticks <= ticks + 32'd1;
              if (rv) begin
                slice <= slice_dec;
                req   <= (slice_dec == '0);
              end
            end
            prrts_pkg::MODE_SWITCH: begin
              if (total != '0) begin
                scan_cnt <= '0;
                state    <= S_SCAN;
              end
            end
            prrts_pkg::MODE_CREATE: begin
              if (total < TW'(THREAD_SLOTS)) begin
                total <= total + TW'(1);
                cok   <= 1'b1;
                cidx  <= IW'(total);
              end
            end
            prrts_pkg::MODE_SLEEP, prrts_pkg::MODE_EXIT, prrts_pkg::MODE_BLOCK: begin
              req <= cur_run;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          // wait here while the candidate travels down the row of cells to its end
          scan_cnt <= scan_cnt + IW'(1);
          if (scan_cnt == IW'(THREAD_SLOTS - 1)) state <= S_DEMOTE;
        end
        S_DEMOTE: begin
          win   <= cand_w[THREAD_SLOTS].idx[IW-1:0];
          state <= cand_w[THREAD_SLOTS].valid ? S_RUN : S_DONE;
        end
        S_RUN: begin
          rs     <= win;
          rv     <= 1'b1;
          slice  <= quantum;
          nvalid <= 1'b1;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!sched_out.valid || sched_out.ready) begin
            sched_out.valid          <= 1'b1;
            sched_out.switch_request <= req;
            sched_out.next_valid     <= nvalid;
            sched_out.next_index     <= prrts_pkg::OIDX_W'(rs);
            sched_out.created_ok     <= cok;
            sched_out.created_index  <= prrts_pkg::OIDX_W'(cidx);
            sched_out.tick_now       <= ticks;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PRRTS_ASSERT(a_total_bound, clk, rst, total <= TW'(THREAD_SLOTS), "thread count over table size")
  `PRRTS_ASSERT(a_running_in_table, clk, rst, rv |-> (TW'(rs) < total), "running slot outside table")
  `PRRTS_ASSERT(a_run_after_demote, clk, rst, (state == S_RUN) |-> ($past(state) == S_DEMOTE), "dispatch without selection")
  `PRRTS_ASSERT(a_run_sets_valid, clk, rst, (state == S_RUN) |=> rv, "dispatch left no running thread")
endmodule

### rtl/core/prrts_cell.sv
// one thread slot: its entry plus one stage of the selection chain
module prrts_cell (
  input  logic                         clk,
  input  prrts_pkg::cmd_t              cmd,
  input  logic [prrts_pkg::SEL_W-1:0]  my_id,
  input  prrts_pkg::cand_t             cand_in,
  output prrts_pkg::cand_t             cand_out,
  output prrts_pkg::status_t           status_o
);
  prrts_pkg::status_t              status;
  logic [prrts_pkg::PRIO_W-1:0]    prio;
  logic [prrts_pkg::TICK_W-1:0]    period;
  logic [prrts_pkg::TICK_W-1:0]    rel;
  logic                            hit;
  logic                            live;
  logic                            mine;
  logic [prrts_pkg::TICK_W-1:0]    wake_diff;
  logic [prrts_pkg::SEL_W:0]       dist_wide;
  prrts_pkg::cand_t                cand_next;

  assign hit       = (cmd.sel == my_id);
  assign live      = ({1'b0, my_id} < cmd.total);
  assign wake_diff = cmd.ticks + 32'd1 - rel;
  assign status_o  = status;

  // rotated distance from the slot after the current one
  always_comb begin
    if (my_id >= cmd.start) begin
      dist_wide = {1'b0, my_id} - {1'b0, cmd.start};
    end else begin
      dist_wide = {1'b0, my_id} + cmd.total - {1'b0, cmd.start};
    end
  end

  assign mine = live && (status == prrts_pkg::ST_READY || status == prrts_pkg::ST_RUNNING);

  always_comb begin
    cand_next = cand_in;
    if (mine && (!cand_in.valid || prio > cand_in.prio ||
        (prio == cand_in.prio && dist_wide[prrts_pkg::SEL_W-1:0] < cand_in.rot))) begin
      cand_next.valid = 1'b1;
      cand_next.prio  = prio;
      cand_next.rot   = dist_wide[prrts_pkg::SEL_W-1:0];
      cand_next.idx   = my_id;
    end
  end

  always_ff @(posedge clk) begin
    cand_out <= cand_next;
    case (cmd.op)
      prrts_pkg::OP_TICK: begin
        if (status == prrts_pkg::ST_BLOCKED && period != '0 && cmd.ticks >= rel) begin
          status <= prrts_pkg::ST_READY;
          rel    <= cmd.ticks + period;
        end else if (status == prrts_pkg::ST_SLEEPING && !wake_diff[prrts_pkg::TICK_W-1]) begin
          status <= prrts_pkg::ST_READY;
        end
      end
      prrts_pkg::OP_CREATE: if (hit) begin
        status <= prrts_pkg::ST_READY;
        prio   <= cmd.prio;
        period <= cmd.data;
        rel    <= cmd.ticks + cmd.data;
      end
      prrts_pkg::OP_SLEEP: if (hit) begin
        status <= prrts_pkg::ST_SLEEPING;
        period <= cmd.data;
        rel    <= cmd.ticks + cmd.data;
      end
      prrts_pkg::OP_EXIT:   if (hit) status <= prrts_pkg::ST_TERMINATED;
      prrts_pkg::OP_BLOCK:  if (hit) status <= prrts_pkg::ST_BLOCKED;
      prrts_pkg::OP_DEMOTE: if (hit) status <= prrts_pkg::ST_READY;
      prrts_pkg::OP_RUN:    if (hit) status <= prrts_pkg::ST_RUNNING;
      default: ;
    endcase
  end
endmodule

### test/tb_prrts_intf.sv
// testbench channel notes: the scheduler channel interfaces of the rtl are used as they are

### test/tb_priority_round_robin_thread_scheduler_top.sv
// testbench of the thread scheduler: directed and random events checked against a predictor
module tb_priority_round_robin_thread_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 8;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic        switch_request;
    logic        next_valid;
    logic [2:0]  next_index;
    logic        created_ok;
    logic [2:0]  created_index;
    logic [31:0] tick_now;
  } sched_result_t;

  // scheduler shadow: thread table, tick count and slice, plus queued answers
  class sched_scoreboard;
    prrts_pkg::status_t status[SLOTS];
    logic [7:0]    prio[SLOTS];
    logic [31:0]   period[SLOTS];
    logic [31:0]   release_at[SLOTS];
    int            total;
    int            cur;
    bit            cur_valid;
    logic [31:0]   ticks;
    logic [15:0]   slice;
    logic [15:0]   quantum;
    logic [31:0]   def_period;
    sched_result_t pending[$];
    int            errors;
    int            checked;
    int            switches_found;
    int            creates_full;

    function void clear();
      total = 0; cur = 0; cur_valid = 0; ticks = 0; slice = 0;
      quantum = prrts_pkg::QUANTUM_RST; def_period = prrts_pkg::PERIOD_RST;
      pending.delete();
    endfunction

    function bit runnable(int i);
      return status[i] == prrts_pkg::ST_READY || status[i] == prrts_pkg::ST_RUNNING;
    endfunction

    function bit cur_running();
      return cur_valid && cur < total && status[cur] == prrts_pkg::ST_RUNNING;
    endfunction

    // note one accepted event and queue its expected answer
    function void note_event(logic [2:0] mode, logic [7:0] p, logic [31:0] dly);
      sched_result_t r;
      logic [31:0] prev;
      logic [31:0] d;
      logic [7:0] best;
      bit found;
      int idx;
      r = '0;
      case (mode)
        prrts_pkg::MODE_TICK: begin
          prev = ticks;
          ticks = ticks + 1;
          for (int i = 0; i < total; i++) begin
            if (status[i] == prrts_pkg::ST_BLOCKED && period[i] != 0 &&
                prev >= release_at[i]) begin
              status[i] = prrts_pkg::ST_READY;
              release_at[i] = prev + period[i];
            end
            d = ticks - release_at[i];
            if (status[i] == prrts_pkg::ST_SLEEPING && !d[31]) status[i] = prrts_pkg::ST_READY;
          end
          if (cur_valid) begin
            if (slice != 0) slice = slice - 1;
            if (slice == 0) r.switch_request = 1;
          end
        end
        prrts_pkg::MODE_SWITCH: begin
          if (cur_running()) status[cur] = prrts_pkg::ST_READY;
          found = 0; best = 0;
          for (int i = 0; i < total; i++)
            if (runnable(i) && (!found || prio[i] > best)) begin
              best = prio[i]; found = 1;
            end
          if (found) begin
            for (int o = 0; o < total; o++) begin
              idx = (cur + 1 + o) % total;
              if (runnable(idx) && prio[idx] == best) begin
                cur = idx;
                break;
              end
            end
            cur_valid = 1;
            status[cur] = prrts_pkg::ST_RUNNING;
            slice = quantum;
            r.next_valid = 1;
            switches_found++;
          end
        end
        prrts_pkg::MODE_CREATE: begin
          if (total < SLOTS) begin
            status[total] = prrts_pkg::ST_READY;
            prio[total] = p;
            period[total] = def_period;
            release_at[total] = ticks + def_period;
            r.created_ok = 1;
            r.created_index = total[2:0];
            total++;
          end else creates_full++;
        end
        prrts_pkg::MODE_SLEEP, prrts_pkg::MODE_EXIT, prrts_pkg::MODE_BLOCK: begin
          if (cur_running()) begin
            if (mode == prrts_pkg::MODE_SLEEP) begin
              period[cur] = dly;
              release_at[cur] = ticks + dly;
              status[cur] = prrts_pkg::ST_SLEEPING;
            end else if (mode == prrts_pkg::MODE_EXIT) status[cur] = prrts_pkg::ST_TERMINATED;
            else status[cur] = prrts_pkg::ST_BLOCKED;
            r.switch_request = 1;
          end
        end
        default: ;
      endcase
      r.next_index = cur[2:0];
      r.tick_now = ticks;
      pending.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t want;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.switch_request !== want.switch_request) begin
        $error("switch_request expected %0d got %0d", want.switch_request, got.switch_request);
        errors++;
      end
      if (got.next_valid !== want.next_valid) begin
        $error("next_valid expected %0d got %0d", want.next_valid, got.next_valid);
        errors++;
      end
      if (got.next_index !== want.next_index) begin
        $error("next_index expected %0d got %0d", want.next_index, got.next_index);
        errors++;
      end
      if (got.created_ok !== want.created_ok) begin
        $error("created_ok expected %0d got %0d", want.created_ok, got.created_ok);
        errors++;
      end
      if (got.created_index !== want.created_index) begin
        $error("created_index expected %0d got %0d", want.created_index, got.created_index);
        errors++;
      end
      if (got.tick_now !== want.tick_now) begin
        $error("tick_now expected %0h got %0h", want.tick_now, got.tick_now);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;

  prrts_in_if  sched_in ();
  prrts_out_if sched_out ();
  prrts_cfg_if cfg ();

  priority_round_robin_thread_scheduler_top uut (
    .clk(clk), .rst(rst), .sched_in(sched_in), .sched_out(sched_out), .cfg(cfg)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  sched_scoreboard sb;
  bit quiet;         // last part of the run: no idling on either side
  bit sink_stall_on;
  int sink_hold = 0;
  int idle_cycles;
  int events_sent;
  int cfg_writes;

  initial begin
    sb = new();
    sb.errors = 0;
    sb.clear();
    sched_in.valid = 0;
    sched_in.mode = prrts_pkg::MODE_TICK;
    sched_in.new_priority = 0;
    sched_in.sleep_ticks = 0;
    sched_out.ready = 0;
    cfg.valid = 0;
    cfg.index = prrts_pkg::CFG_QUANTUM;
    cfg.data = 0;
  end

  // result side: ready with random stall bursts, checked at the rising edge
  always @(negedge clk) begin
    if (rst || quiet || !sink_stall_on) begin
      sched_out.ready <= !rst;
    end else if (sink_hold > 0) begin
      sched_out.ready <= 0;
      sink_hold <= sink_hold - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      sched_out.ready <= 0;
      sink_hold <= $urandom_range(0, 2);
    end else begin
      sched_out.ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && sched_out.valid && sched_out.ready)
      sb.check_result({sched_out.switch_request, sched_out.next_valid, sched_out.next_index,
                       sched_out.created_ok, sched_out.created_index, sched_out.tick_now});
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (sched_in.valid && sched_in.ready) || (sched_out.valid && sched_out.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("priority_round_robin_thread_scheduler_top: mismatch");
      $finish;
    end
  end

  // one event transaction; valid stays high until the handshake and may be
  // lowered by the next call, when it idles first, or by drain
  task automatic send_event(input logic [2:0] mode, input logic [7:0] p, input logic [31:0] d);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      sched_in.valid <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    sched_in.valid <= 1;
    sched_in.mode <= mode;
    sched_in.new_priority <= p;
    sched_in.sleep_ticks <= d;
    @(posedge clk);
    while (!sched_in.ready) @(posedge clk);
    sb.note_event(mode, p, d);
    events_sent++;
    @(negedge clk);
  endtask

  // wait until every expected result has arrived, then let the block settle
  task automatic drain();
    sched_in.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic [prrts_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == prrts_pkg::CFG_QUANTUM) sb.quantum = value[15:0];
    else sb.def_period = value;
    cfg_writes++;
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  // random event mix weighted toward a living table
  task automatic random_event();
    int pick;
    logic [2:0] m;
    logic [31:0] d;
    pick = $urandom_range(0, 99);
    if (pick < 35) m = prrts_pkg::MODE_TICK;
    else if (pick < 60) m = prrts_pkg::MODE_SWITCH;
    else if (pick < 68) m = prrts_pkg::MODE_CREATE;
    else if (pick < 80) m = prrts_pkg::MODE_SLEEP;
    else if (pick < 87) m = prrts_pkg::MODE_EXIT;
    else if (pick < 97) m = prrts_pkg::MODE_BLOCK;
    else m = 3'($urandom_range(6, 7));
    case ($urandom_range(0, 5))
      0: d = $urandom();
      1: d = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: d = $urandom_range(0, 12);
    endcase
    send_event(m, 8'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 3)), d);
  endtask

  // reset is given only once at the start, so phases
  // keep the table and only vary the registers between them
  initial begin
    logic [15:0] quanta[4];
    logic [31:0] periods[4];
    quanta = '{16'd0, 16'hFFFF, 16'd1, 16'd3};
    periods = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd5};
    quiet = 0;
    sink_stall_on = 1;
    events_sent = 0;
    cfg_writes = 0;
    repeat (9) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: empty table corner cases and odd modes
    send_event(prrts_pkg::MODE_SWITCH, 0, 0);
    send_event(prrts_pkg::MODE_SLEEP, 0, 5);
    send_event(prrts_pkg::MODE_EXIT, 0, 0);
    send_event(prrts_pkg::MODE_BLOCK, 0, 0);
    send_event(3'd6, 8'hFF, 32'hFFFF_FFFF);
    send_event(3'd7, 0, 0);
    send_event(prrts_pkg::MODE_TICK, 0, 0);
    // equal priorities rotate, a max priority wins
    send_event(prrts_pkg::MODE_CREATE, 8'd0, 0);
    send_event(prrts_pkg::MODE_CREATE, 8'd0, 0);
    send_event(prrts_pkg::MODE_CREATE, 8'hFF, 0);
    send_event(prrts_pkg::MODE_SWITCH, 0, 0);
    send_event(prrts_pkg::MODE_SLEEP, 0, 32'hFFFF_FFFF);
    send_event(prrts_pkg::MODE_SWITCH, 0, 0);
    send_event(prrts_pkg::MODE_SWITCH, 0, 0);
    send_event(prrts_pkg::MODE_BLOCK, 0, 0);
    send_event(prrts_pkg::MODE_SWITCH, 0, 0);
    send_event(prrts_pkg::MODE_EXIT, 0, 0);
    for (int k = 0; k < 6; k++) send_event(prrts_pkg::MODE_CREATE, 8'($urandom()), 0);
    send_event(prrts_pkg::MODE_TICK, 0, 0);
    send_event(prrts_pkg::MODE_SWITCH, 0, 0);
    drain();

    // random phases, each under a different register setting
    for (int ph = 0; ph < 5; ph++) begin
      if (ph < 4) begin
        write_reg(prrts_pkg::CFG_QUANTUM, {16'd0, quanta[ph]});
        write_reg(prrts_pkg::CFG_PERIOD, periods[ph]);
      end else begin
        write_reg(prrts_pkg::CFG_QUANTUM, {16'd0, 16'($urandom_range(0, 20))});
        write_reg(prrts_pkg::CFG_PERIOD, $urandom());
        quiet = 1;
        sink_stall_on = 0;
      end
      for (int n = 0; n < 200; n++) begin
        random_event();
        if (ph == 2 && n == 100) drain();  // sender holds off until all results are back
      end
      drain();
    end

    $display("ran %0d events, %0d results checked, %0d register writes", events_sent,
             sb.checked, cfg_writes);
    $display("%0d switches dispatched a thread, %0d creates hit a full table",
             sb.switches_found, sb.creates_full);
    if (sb.errors == 0) begin
      $display("priority_round_robin_thread_scheduler_top: match");
    end else begin
      $display("priority_round_robin_thread_scheduler_top: mismatch");
    end
    $finish;
  end
endmodule

### priority_round_robin_thread_scheduler_top.f
+incdir+rtl/core
rtl/core/prrts_pkg.sv
rtl/core/prrts_intf.sv
rtl/core/prrts_cell.sv
rtl/core/priority_round_robin_thread_scheduler_top.sv
test/tb_prrts_intf.sv
test/tb_priority_round_robin_thread_scheduler_top.sv
